FILE: hdl/sitoa_pkg.sv
`default_nettype none

package sitoa_pkg;

    localparam int DEF_INPUT_BITS = 32;
    // magnitude bits folded into the BCD register per conversion cycle
    localparam int STEP_BITS      = 4;
    localparam int CHAR_BITS      = 6;

    localparam logic [CHAR_BITS-1:0] CODE_MINUS = 6'd45;
    localparam logic [CHAR_BITS-1:0] CODE_ZERO  = 6'd48;

    // decimal digits needed for an n-bit unsigned magnitude (1233/4096 ~ log10 2)
    function automatic int dec_digits(input int n);
        return (n * 1233) / 4096 + 1;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/sitoa_dabble.sv
`default_nettype none

// Shift-and-add-3 step: folds STEP_BITS binary bits, MSB first, into a BCD word.
module sitoa_dabble #(
    parameter int NDIG = 10
) (
    input  wire logic [NDIG*4-1:0]                 i_bcd,
    input  wire logic [sitoa_pkg::STEP_BITS-1:0]   i_bits,
    output logic      [NDIG*4-1:0]                 o_bcd
);
    import sitoa_pkg::*;

    localparam int BCD_W = NDIG * 4;

    logic [BCD_W-1:0] bcd_work;

    always_comb begin
        bcd_work = i_bcd;
        for (int s = 0; s < STEP_BITS; s++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (bcd_work[d*4 +: 4] >= 4'd5) begin
                    bcd_work[d*4 +: 4] = bcd_work[d*4 +: 4] + 4'd3;
                end
            end
            bcd_work = {bcd_work[BCD_W-2:0], i_bits[STEP_BITS-1-s]};
        end
        o_bcd = bcd_work;
    end

endmodule

`default_nettype wire

FILE: hdl/signed_int_to_decimal_ascii.sv
`default_nettype none

// Channel | Dir | Handshake          | Word
// --------+-----+--------------------+-----------------------------------
// input   | in  | i_valid / o_stall  | i_value (INPUT_BITS, signed)
// output  | out | o_valid / i_stall  | o_char_code (6), o_last_char (1)
//
// One word in: a load, then ceil(INPUT_BITS/4) double-dabble steps through the
// shared shift/add-3 unit, a minus for a negative word, then the BCD digit positions
// (dec_digits, 10 at 32 bits), each emitted when the output slot is free; leading
// zeros are dropped one per cycle.
// o_stall is high from accept until the final character enters the output register.
// The output register lets the last character wait while the next word is taken.
// Reset is synchronous, active low, and clears control state only.
module signed_int_to_decimal_ascii #(
    parameter int INPUT_BITS = sitoa_pkg::DEF_INPUT_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic signed [INPUT_BITS-1:0]    i_value,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [sitoa_pkg::CHAR_BITS-1:0]      o_char_code,
    output logic                                 o_last_char
);
    import sitoa_pkg::*;

    localparam int STEPS  = (INPUT_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PW     = STEPS * STEP_BITS;
    localparam int NDIG   = dec_digits(INPUT_BITS);
    localparam int BCD_W  = NDIG * 4;
    localparam int CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int REM_W  = $clog2(NDIG + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SIGN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [PW-1:0]         r_bin, n_bin;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic                  r_neg, n_neg;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic                  r_started, n_started;
    logic                  r_ovalid, n_ovalid;
    logic [CHAR_BITS-1:0]  r_char, n_char;
    logic                  r_last, n_last;

    logic [INPUT_BITS-1:0] mag;
    logic [BCD_W-1:0]      step_bcd;
    logic [3:0]            top_dig;
    logic                  slot_free;
    logic                  in_acc;

    sitoa_dabble #(
        .NDIG (NDIG)
    ) u_dabble (
        .i_bcd  (r_bcd),
        .i_bits (r_bin[PW-1 -: STEP_BITS]),
        .o_bcd  (step_bcd)
    );

    assign o_stall     = (r_state != S_IDLE);
    assign in_acc      = i_valid && !o_stall;
    assign slot_free   = !r_ovalid || !i_stall;
    assign top_dig     = r_bcd[BCD_W-1 -: 4];
    assign mag         = i_value[INPUT_BITS-1] ? (~i_value + 1'b1) : i_value;
    assign o_valid     = r_ovalid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

    always_comb begin
        n_state   = r_state;
        n_bin     = r_bin;
        n_bcd     = r_bcd;
        n_neg     = r_neg;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_started = r_started;
        n_ovalid  = r_ovalid && i_stall;
        n_char    = r_char;
        n_last    = r_last;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_bin     = PW'(mag);
                    n_bcd     = '0;
                    n_neg     = i_value[INPUT_BITS-1];
                    n_cnt     = '0;
                    n_rem     = REM_W'(NDIG);
                    n_started = 1'b0;
                    n_state   = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = step_bcd;
                n_bin = r_bin << STEP_BITS;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_char   = CODE_MINUS;
                    n_last   = 1'b0;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_started && top_dig == 4'd0 && r_rem > REM_W'(1)) begin
                    // leading zero: drop it, no character
                    n_bcd = r_bcd << 4;
                    n_rem = r_rem - 1'b1;
                end else if (slot_free) begin
                    n_ovalid  = 1'b1;
                    n_char    = CODE_ZERO + CHAR_BITS'(top_dig);
                    n_last    = (r_rem == REM_W'(1));
                    n_bcd     = r_bcd << 4;
                    n_rem     = r_rem - 1'b1;
                    n_started = 1'b1;
                    if (r_rem == REM_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_bin     <= n_bin;
        r_bcd     <= n_bcd;
        r_neg     <= n_neg;
        r_cnt     <= n_cnt;
        r_rem     <= n_rem;
        r_started <= n_started;
        r_char    <= n_char;
        r_last    <= n_last;
    end

    a_accept_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == S_CONV)
        else $error("accepted word did not start conversion");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_char == CODE_MINUS |-> !r_last)
        else $error("minus sign marked as last character");

    a_emit_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_rem != '0)
        else $error("digit counter ran out while emitting");

    a_emit_digit_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> top_dig <= 4'd9)
        else $error("invalid BCD digit at emit");

    a_sign_only_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SIGN |-> r_neg)
        else $error("sign state on non-negative word");

endmodule

`default_nettype wire
